### rtl/core/sfc_pkg.sv
// Package for the sensor packet framer: record and frame byte types, frame
// constants and the CRC-8 byte update. No dependencies.
`default_nettype none

package sfc_pkg;

  localparam int unsigned SFC_FRAME_LEN = 12;
  localparam int unsigned SFC_IDX_W     = 4;
  localparam int unsigned SFC_QDEPTH    = 2;

  localparam logic [7:0] SFC_CRC_POLY = 8'h07;
  localparam logic [7:0] SFC_CRC_INIT = 8'h00;

  // Index of the trailing CRC byte.
  localparam logic [SFC_IDX_W-1:0] SFC_LAST_IDX = SFC_IDX_W'(SFC_FRAME_LEN - 1);

  typedef struct packed {
    logic [7:0]  dev_id;
    logic [31:0] temperature_bits;
    logic [15:0] humidity;
    logic [31:0] timestamp;
  } sfc_rec_t;

  typedef struct packed {
    logic [7:0]           frame_byte;
    logic [SFC_IDX_W-1:0] byte_index;
    logic                 last_byte;
  } sfc_byte_t;

  // One byte through the MSB-first CRC-8 shift register.
  function automatic logic [7:0] sfc_crc8(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] v;
    v = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ SFC_CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sfc_front.sv
// Front end of the framer: accepts sensor records into a short queue.
// Depends on sfc_pkg.
`default_nettype none

module sfc_front import sfc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = SFC_QDEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire sfc_rec_t in_item,
  output logic          q_valid,
  input  wire logic     q_take,
  output sfc_rec_t      q_rec
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  sfc_rec_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_rec   = slot_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sfc_back.sv
// Back end of the framer: serializes one record into frame bytes, folds
// each body byte into the running CRC and holds the result in an output
// register. Depends on sfc_pkg.
`default_nettype none

module sfc_back import sfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  output logic          q_take,
  input  wire sfc_rec_t q_rec,
  output logic          empty,
  input  wire logic     pop,
  output sfc_byte_t     out_item
);

  sfc_rec_t             rec_r, rec_nxt;
  logic                 rec_valid_r, rec_valid_nxt;
  logic [SFC_IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]           crc_r, crc_nxt;
  sfc_byte_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free, emit, at_last;
  logic [7:0]           cur_byte;

  assign out_free = !out_valid_r || pop;
  assign emit     = rec_valid_r && out_free;
  assign at_last  = (idx_r == SFC_LAST_IDX);
  assign q_take   = q_valid && (!rec_valid_r || (emit && at_last));
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  always_comb begin
    case (idx_r)
      4'd0:    cur_byte = rec_r.dev_id;
      4'd1:    cur_byte = rec_r.temperature_bits[7:0];
      4'd2:    cur_byte = rec_r.temperature_bits[15:8];
      4'd3:    cur_byte = rec_r.temperature_bits[23:16];
      4'd4:    cur_byte = rec_r.temperature_bits[31:24];
      4'd5:    cur_byte = rec_r.humidity[7:0];
      4'd6:    cur_byte = rec_r.humidity[15:8];
      4'd7:    cur_byte = rec_r.timestamp[7:0];
      4'd8:    cur_byte = rec_r.timestamp[15:8];
      4'd9:    cur_byte = rec_r.timestamp[23:16];
      4'd10:   cur_byte = rec_r.timestamp[31:24];
      default: cur_byte = crc_r;
    endcase
  end

  always_comb begin
    rec_nxt       = rec_r;
    rec_valid_nxt = rec_valid_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    if (emit) begin
      out_nxt.frame_byte = cur_byte;
      out_nxt.byte_index = idx_r;
      out_nxt.last_byte  = at_last;
      out_valid_nxt      = 1'b1;
      // The first byte restarts the CRC from its initial value.
      crc_nxt = sfc_crc8((idx_r == '0) ? SFC_CRC_INIT : crc_r, cur_byte);
      if (at_last) begin
        idx_nxt       = '0;
        rec_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (q_take) begin
      rec_nxt       = q_rec;
      rec_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    crc_r <= crc_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/sensor_packet_framer_crc8_core.sv
// Top level of the sensor packet framer with CRC-8 trailer.
// Instantiates sfc_front and sfc_back; depends on sfc_pkg.
//
//   Channel   Handshake         Payload             Direction
//   input     push / full       in_item (record)    into the block
//   result    pop / empty       out_item (byte)     out of the block
//
// Each record becomes twelve result items, one per cycle while pop keeps up.
// On an idle block the first byte goes from the queue slot through the record
// register into the output register before it reaches the result ports. A
// new record is loaded at the same edge that moves the previous CRC byte into
// the output register, so frames follow each other with no gap while records
// are waiting. Reset (rst_n low at a clock edge) empties the record queue and
// drops any frame in progress. When pop stays low the output register holds
// its item and the back end waits, while the front queue keeps taking records
// until it is full.
`default_nettype none

module sensor_packet_framer_crc8_core import sfc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = SFC_QDEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire sfc_rec_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output sfc_byte_t     out_item
);

  // Record queue between the accepting front end and the serializer.
  logic     q_valid;
  logic     q_take;
  sfc_rec_t q_rec;

  sfc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_rec   (q_rec)
  );

  // The back end walks the frame byte by byte, computing the CRC as the
  // body bytes go out, and emits the CRC as the twelfth byte.
  sfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_rec    (q_rec),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
